// File: rtl/rsnr_pkg.sv
// ----------------------------------------------------------------------------
// rsnr_pkg: shared constants and types for the random sample unit
// widths, register indexes, command codes and reset values
// ----------------------------------------------------------------------------
package rsnr_pkg;

   // pool and random word geometry
   localparam int POOL_SIZE  = 64;
   localparam int RND_WIDTH  = 31;
   localparam int IDX_W      = (POOL_SIZE > 2) ? $clog2(POOL_SIZE) : 1;
   localparam int DIV_W      = IDX_W + 1;
   localparam int RCNT_W     = $clog2(RND_WIDTH);

   // field widths
   localparam int VALUE_W    = 8;
   localparam int COUNT_W    = 7;
   localparam int PICK_W     = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   typedef logic [VALUE_W-1:0]   value_type;
   typedef logic [IDX_W-1:0]     idx_type;
   typedef logic [COUNT_W-1:0]   count_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   // register indexes
   localparam csr_idx_type CSR_POOL_LO      = 2'd0;
   localparam csr_idx_type CSR_POOL_HI      = 2'd1;
   localparam csr_idx_type CSR_SAMPLE_COUNT = 2'd2;

   // commands
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_DRAW  = 1'b1;

   // register reset values
   localparam value_type POOL_LO_RST      = 8'd1;
   localparam value_type POOL_HI_RST      = 8'd33;
   localparam count_type SAMPLE_COUNT_RST = 7'd6;

endpackage

// File: rtl/rsnr_if.sv
// ----------------------------------------------------------------------------
// rsnr_if: channel interfaces of the random sample unit
// request, response and register write channels, valid/ready handshake
// ----------------------------------------------------------------------------
interface rsnr_req_if;
   import rsnr_pkg::*;
   logic                 valid;
   logic                 ready;
   logic                 cmd;
   logic [RND_WIDTH-1:0] rnd_word;
   modport source (output valid, cmd, rnd_word, input ready);
   modport sink   (input valid, cmd, rnd_word, output ready);
endinterface

interface rsnr_rsp_if;
   import rsnr_pkg::*;
   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] drawn_value;
   logic [PICK_W-1:0]  pick_index;
   logic               last;
   modport source (output valid, drawn_value, pick_index, last, input ready);
   modport sink   (input valid, drawn_value, pick_index, last, output ready);
endinterface

interface rsnr_csr_if;
   import rsnr_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/rsnr_mod_unit.sv
// ----------------------------------------------------------------------------
// rsnr_mod_unit: bit-serial remainder of a random word by a small divisor
// restoring scheme, one word bit per cycle, msb first
// ----------------------------------------------------------------------------
module rsnr_mod_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [rsnr_pkg::RND_WIDTH-1:0] word,
   input  logic [rsnr_pkg::DIV_W-1:0]     divisor,
   output logic                          done,
   output logic [rsnr_pkg::IDX_W-1:0]     remainder
);
   import rsnr_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [RCNT_W-1:0]    cnt_ff, cnt_in;
   logic [RND_WIDTH-1:0] sr_ff, sr_in;
   logic [IDX_W-1:0]     rem_ff, rem_in;
   logic [DIV_W-1:0]     div_ff, div_in;
   logic [DIV_W-1:0]     trial;

   // partial remainder with the next word bit shifted in
   assign trial = {rem_ff, sr_ff[RND_WIDTH-1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      sr_in   = sr_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = RCNT_W'(RND_WIDTH - 1);
         sr_in   = word;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         sr_in = {sr_ff[RND_WIDTH-2:0], 1'b0};
         if (trial >= div_ff) begin
            rem_in = IDX_W'(trial - div_ff);
         end else begin
            rem_in = trial[IDX_W-1:0];
         end
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      sr_ff  <= sr_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// File: rtl/random_sample_no_repeat_unit.sv
// ----------------------------------------------------------------------------
// random_sample_no_repeat_unit: distinct value sampler
// partial fisher-yates shuffle over a remap table, one pick per draw item
// ----------------------------------------------------------------------------
// A start item (cmd 0) opens a draw sequence over the configured value range;
// it clears the remap marks at once, so no clearing pass is needed. A draw
// item (cmd 1) brings a random word and returns one distinct value, its
// position in the sequence and a last flag; draws beyond the sample count,
// after the pool is spent, or in a sequence whose range is reversed or wider
// than the pool give no item. For a productive draw the remainder of the word
// by the number of remaining values is formed one word bit per cycle in a
// serial unit, followed by two reads and, unless the pick is the top slot, a
// write-back on the remap memory. The result sits in an output register, so
// a new item is accepted while an earlier pick still waits to be taken.
// Registers must be written only while the unit is idle; the unit itself
// does not enforce this.
// ----------------------------------------------------------------------------
module random_sample_no_repeat_unit (
   input logic       clock,
   input logic       reset,
   rsnr_req_if.sink   req_if,
   rsnr_rsp_if.source rsp_if,
   rsnr_csr_if.sink   csr_if
);
   import rsnr_pkg::*;

   // sequencer states
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DIVIDE = 3'd1;
   localparam logic [2:0] ST_RD_I   = 3'd2;
   localparam logic [2:0] ST_RD_N   = 3'd3;
   localparam logic [2:0] ST_EMIT   = 3'd4;

   // configuration registers
   value_type pool_lo_ff, pool_hi_ff;
   count_type sample_count_ff;

   // sequence state
   logic [2:0]           state_ff, state_in;
   idx_type              span_ff, span_in;
   logic                 empty_ff, empty_in;
   count_type            picks_ff, picks_in;
   logic [POOL_SIZE-1:0] vld_ff, vld_in;

   // per draw working registers
   idx_type   idx_ff;
   logic      vld_i_ff, vld_n_ff;
   value_type rd_q_ff;
   value_type pick_ff;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   value_type         rsp_value_ff;
   logic [PICK_W-1:0] rsp_pick_ff;
   logic              rsp_last_ff;

   // remap memory
   value_type tbl_mem [POOL_SIZE];
   idx_type   tbl_raddr;
   logic      tbl_we;
   value_type tbl_wdata;

   // serial remainder unit
   logic             mod_start;
   logic             mod_done;
   logic [DIV_W-1:0] mod_div;
   idx_type          mod_rem;

   logic                  req_take, csr_take, out_free;
   logic [VALUE_W-1:0]    diff;
   logic                  bad_range;
   logic                  draw_ok;

   assign req_take = req_if.valid && req_if.ready;
   assign csr_take = csr_if.valid && csr_if.ready;
   assign out_free = !rsp_valid_ff || rsp_if.ready;

   // span of a new sequence; reversed or too wide leaves the pool empty
   assign diff      = pool_hi_ff - pool_lo_ff;
   assign bad_range = (pool_hi_ff < pool_lo_ff) ||
                      ({1'b0, diff} >= (VALUE_W+1)'(POOL_SIZE));

   // a draw only does work while picks remain and the pool is not spent
   assign draw_ok   = !empty_ff && (picks_ff < sample_count_ff);
   assign mod_start = req_take && (req_if.cmd == CMD_DRAW) && draw_ok;
   assign mod_div   = {1'b0, span_ff} + DIV_W'(1);

   rsnr_mod_unit u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .word      (req_if.rnd_word),
      .divisor   (mod_div),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   // the index is read first, then the top of the remaining pool
   assign tbl_raddr = (state_ff == ST_RD_I) ? idx_ff : span_ff;
   // slot i takes what the top slot maps to
   assign tbl_wdata = vld_n_ff ? rd_q_ff : VALUE_W'(span_ff);

   always_comb begin
      state_in     = state_ff;
      span_in      = span_ff;
      empty_in     = empty_ff;
      picks_in     = picks_ff;
      vld_in       = vld_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      tbl_we       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_if.cmd == CMD_START) begin
                  vld_in   = '0;
                  picks_in = '0;
                  if (bad_range) begin
                     span_in  = '0;
                     empty_in = 1'b1;
                  end else begin
                     span_in  = diff[IDX_W-1:0];
                     empty_in = 1'b0;
                  end
               end else if (draw_ok) begin
                  state_in = ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            if (mod_done) begin
               state_in = ST_RD_I;
            end
         end
         ST_RD_I: state_in = ST_RD_N;
         ST_RD_N: state_in = ST_EMIT;
         ST_EMIT: begin
            // hold until the output register is free, then commit the swap
            if (out_free) begin
               rsp_valid_in = 1'b1;
               picks_in     = picks_ff + 1'b1;
               if (idx_ff != span_ff) begin
                  tbl_we         = 1'b1;
                  vld_in[idx_ff] = 1'b1;
               end
               if (span_ff == '0) begin
                  empty_in = 1'b1;
               end else begin
                  span_in = span_ff - 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         span_ff         <= '0;
         empty_ff        <= 1'b1;
         picks_ff        <= '0;
         vld_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
         pool_lo_ff      <= POOL_LO_RST;
         pool_hi_ff      <= POOL_HI_RST;
         sample_count_ff <= SAMPLE_COUNT_RST;
      end else begin
         state_ff     <= state_in;
         span_ff      <= span_in;
         empty_ff     <= empty_in;
         picks_ff     <= picks_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_take) begin
            unique case (csr_if.index)
               CSR_POOL_LO:      pool_lo_ff      <= csr_if.data;
               CSR_POOL_HI:      pool_hi_ff      <= csr_if.data;
               CSR_SAMPLE_COUNT: sample_count_ff <= csr_if.data[COUNT_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // remap memory, registered read
   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_mem[idx_ff] <= tbl_wdata;
      end
      rd_q_ff <= tbl_mem[tbl_raddr];
   end

   // per draw payload
   always_ff @(posedge clock) begin
      if (state_ff == ST_DIVIDE && mod_done) begin
         idx_ff <= mod_rem;
      end
      if (state_ff == ST_RD_I) begin
         vld_i_ff <= vld_ff[idx_ff];
      end
      if (state_ff == ST_RD_N) begin
         vld_n_ff <= vld_ff[span_ff];
         // unmarked slots map to themselves
         pick_ff  <= (vld_i_ff ? rd_q_ff : VALUE_W'(idx_ff)) + pool_lo_ff;
      end
      if (state_ff == ST_EMIT && out_free) begin
         rsp_value_ff <= pick_ff;
         rsp_pick_ff  <= picks_ff[PICK_W-1:0];
         rsp_last_ff  <= (count_type'(picks_ff + 1'b1) == sample_count_ff);
      end
   end

   assign req_if.ready       = (state_ff == ST_IDLE);
   assign csr_if.ready       = 1'b1;
   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.drawn_value = rsp_value_ff;
   assign rsp_if.pick_index  = rsp_pick_ff;
   assign rsp_if.last        = rsp_last_ff;

   // the serial unit only finishes while the sequencer waits for it
   a_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      mod_done |-> (state_ff == ST_DIVIDE))
      else $error("remainder finished outside the divide phase");

   // the picked index never exceeds the remaining span
   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      mod_done |-> ({1'b0, mod_rem} < mod_div))
      else $error("remainder not below divisor");

   a_idx_in_span: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (idx_ff <= span_ff))
      else $error("swap index beyond remaining span");

   // a spent or invalid pool always carries a zero span
   a_empty_span: assert property (@(posedge clock) disable iff (reset)
      empty_ff |-> (span_ff == '0))
      else $error("empty pool with non-zero span");

endmodule
